// ----- rtl/lpna_pkg.sv -----
// Shared types, constants and helpers for the length-prefixed NAL to Annex B converter.
package lpna_pkg;

  // Default width of the packet size field.
  localparam int PACKET_SIZE_BITS_DEF = 24;
  // Default number of entries in the command queue between the parser and the emitter.
  localparam int QUEUE_DEPTH_DEF = 4;
  // A length prefix holds at most four bytes.
  localparam int LEN_VALUE_BITS = 32;

  localparam logic [2:0] FIELD_BYTES_RESET = 3'd4;
  localparam logic [2:0] FIELD_BYTES_MIN   = 3'd1;
  localparam logic [2:0] FIELD_BYTES_MAX   = 3'd4;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // Index of the final byte of the four-byte start code.
  localparam logic [1:0] START_CODE_LAST = 2'd3;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  // Kind of work handed from the parser to the emitter.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Clamp the configured prefix size into the range of one to four bytes.
  function automatic logic [2:0] field_bytes(input logic [2:0] cfg);
    logic [2:0] fb;
    if (cfg < FIELD_BYTES_MIN) begin
      fb = FIELD_BYTES_MIN;
    end else if (cfg > FIELD_BYTES_MAX) begin
      fb = FIELD_BYTES_MAX;
    end else begin
      fb = cfg;
    end
    return fb;
  endfunction

endpackage

// ----- rtl/lpna_front.sv -----
// Parser front end: accepts input bytes, tracks length prefixes and queues commands.
module lpna_front #(
  parameter int PACKET_SIZE_BITS = lpna_pkg::PACKET_SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((8 + PACKET_SIZE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                   s_tuser,
  input  logic                   q_full,
  output logic                   push,
  output lpna_pkg::cmd_t         push_cmd
);

  localparam int PSB  = PACKET_SIZE_BITS;
  localparam int LVB  = lpna_pkg::LEN_VALUE_BITS;

  // Configuration and parser state.
  logic [2:0]           length_field_bytes;
  lpna_pkg::phase_t     phase, phase_next;
  logic [1:0]           seen, seen_next;
  logic [LVB-1:0]       lv, lv_next;
  logic [PSB-1:0]       pbl, pbl_next;
  logic [PSB-1:0]       payl, payl_next;

  // Values after a possible packet restart.
  logic                 accept;
  logic [7:0]           in_byte;
  logic [PSB-1:0]       eff_pbl, eff_payl, left, payl_dec;
  lpna_pkg::phase_t     eff_phase;
  logic [1:0]           eff_seen;
  logic [LVB-1:0]       eff_lv, lv_shift;
  logic [LVB:0]         left_ext;
  logic [2:0]           fb;
  logic                 active, len_done, len_bad, pay_done, more;

  assign s_tready = ~q_full;
  assign accept   = s_tvalid & ~q_full;
  assign in_byte  = s_tdata[7:0];

  assign eff_pbl   = s_tuser ? s_tdata[8 +: PSB] : pbl;
  assign eff_phase = s_tuser ? lpna_pkg::PH_LENGTH : phase;
  assign eff_seen  = s_tuser ? 2'd0 : seen;
  assign eff_lv    = s_tuser ? '0 : lv;
  assign eff_payl  = s_tuser ? '0 : payl;

  // Decode of the current byte against the packet and NAL counters.
  assign active   = (eff_pbl != '0);
  assign left     = eff_pbl - PSB'(1);
  assign left_ext = {{(LVB + 1 - PSB){1'b0}}, left};
  assign fb       = lpna_pkg::field_bytes(length_field_bytes);
  assign lv_shift = {eff_lv[LVB-9:0], in_byte};
  assign len_done = ({1'b0, eff_seen} + 3'd1) >= fb;
  assign len_bad  = (lv_shift == '0) || ({1'b0, lv_shift} > left_ext);
  assign payl_dec = (eff_payl != '0) ? eff_payl - PSB'(1) : eff_payl;
  assign pay_done = (payl_dec == '0) || (left == '0);
  assign more     = left > PSB'(2);

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      phase_next = eff_phase;
      if (active) begin
        case (eff_phase)
          lpna_pkg::PH_LENGTH: begin
            if (len_done) begin
              phase_next = len_bad ? lpna_pkg::PH_DROP : lpna_pkg::PH_PAYLOAD;
            end else if (left == '0) begin
              phase_next = lpna_pkg::PH_DROP;
            end
          end
          lpna_pkg::PH_PAYLOAD: begin
            if (pay_done) begin
              phase_next = more ? lpna_pkg::PH_LENGTH : lpna_pkg::PH_DROP;
            end
          end
          default: begin
            phase_next = eff_phase;
          end
        endcase
      end
    end
  end

  // Counter updates and the command, if any, pushed for each accepted byte.
  always_comb begin
    seen_next     = seen;
    lv_next       = lv;
    pbl_next      = pbl;
    payl_next     = payl;
    push          = 1'b0;
    push_cmd.kind = lpna_pkg::CMD_BYTE;
    push_cmd.data = in_byte;
    push_cmd.last = 1'b0;
    if (accept) begin
      seen_next = eff_seen;
      lv_next   = eff_lv;
      pbl_next  = eff_pbl;
      payl_next = eff_payl;
      if (active) begin
        pbl_next = left;
        case (eff_phase)
          lpna_pkg::PH_LENGTH: begin
            if (len_done) begin
              seen_next = 2'd0;
              push      = 1'b1;
              if (len_bad) begin
                lv_next       = lv_shift;
                push_cmd.kind = lpna_pkg::CMD_ERROR;
                push_cmd.data = lpna_pkg::BYTE_ZERO;
                push_cmd.last = 1'b1;
              end else begin
                lv_next       = '0;
                payl_next     = lv_shift[PSB-1:0];
                push_cmd.kind = lpna_pkg::CMD_START;
                push_cmd.data = lpna_pkg::BYTE_ZERO;
              end
            end else begin
              seen_next = eff_seen + 2'd1;
              lv_next   = lv_shift;
              if (left == '0) begin
                push          = 1'b1;
                push_cmd.kind = lpna_pkg::CMD_ERROR;
                push_cmd.data = lpna_pkg::BYTE_ZERO;
                push_cmd.last = 1'b1;
              end
            end
          end
          lpna_pkg::PH_PAYLOAD: begin
            push      = 1'b1;
            payl_next = payl_dec;
            if (pay_done) begin
              payl_next = '0;
              if (more) begin
                seen_next = 2'd0;
                lv_next   = '0;
              end else begin
                push_cmd.last = 1'b1;
              end
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_field_bytes <= lpna_pkg::FIELD_BYTES_RESET;
      phase              <= lpna_pkg::PH_LENGTH;
      seen               <= 2'd0;
      lv                 <= '0;
      pbl                <= '0;
      payl               <= '0;
    end else begin
      if (cfg_we) begin
        length_field_bytes <= cfg_wdata;
      end
      phase <= phase_next;
      seen  <= seen_next;
      lv    <= lv_next;
      pbl   <= pbl_next;
      payl  <= payl_next;
    end
  end

endmodule

// ----- rtl/lpna_queue.sv -----
// Short command queue between the parser and the emitter.
module lpna_queue #(
  parameter int DEPTH = lpna_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpna_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lpna_pkg::cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpna_pkg::cmd_t  entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  // Entry storage; written on a push only.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count missed a push");

endmodule

// ----- rtl/lpna_back.sv -----
// Emitter back end: expands queued commands into output bytes behind an output register.
module lpna_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lpna_pkg::cmd_t head,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic           m_tuser
);

  logic       out_free, emit, is_start;
  logic [1:0] sc_cnt;
  logic [7:0] byte_sel;

  assign out_free = ~m_tvalid | m_tready;
  assign emit     = q_valid & out_free;
  assign is_start = (head.kind == lpna_pkg::CMD_START);
  assign pop      = emit & (~is_start | (sc_cnt == lpna_pkg::START_CODE_LAST));

  // Select the byte for the current command.
  always_comb begin
    case (head.kind)
      lpna_pkg::CMD_START:
        byte_sel = (sc_cnt == lpna_pkg::START_CODE_LAST) ? lpna_pkg::BYTE_ONE
                                                         : lpna_pkg::BYTE_ZERO;
      lpna_pkg::CMD_BYTE:
        byte_sel = head.data;
      default:
        byte_sel = lpna_pkg::BYTE_ZERO;
    endcase
  end

  // Start code position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_cnt <= 2'd0;
    end else if (emit && is_start) begin
      sc_cnt <= sc_cnt + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_sel;
      m_tlast <= head.last & ~is_start;
      m_tuser <= (head.kind == lpna_pkg::CMD_ERROR);
    end
  end

  a_sc_mid_start: assert property (@(posedge clk) disable iff (rst)
    (sc_cnt != 2'd0) |-> (q_valid && is_start))
    else $error("start code counter running without a start command");
  a_start_no_pop_early: assert property (@(posedge clk) disable iff (rst)
    (emit && is_start && sc_cnt != lpna_pkg::START_CODE_LAST) |-> !pop)
    else $error("start command popped before its last byte");

endmodule

// ----- rtl/length_prefixed_nal_to_annexb_unit.sv -----
// Top level of the length-prefixed NAL to Annex B start-code converter.
//
// Input stream: one packet byte per transfer. s_tdata holds data_byte in the
// low byte and packet_size above it; s_tuser is packet_start, set on the first
// byte of a packet. Output stream: one Annex B byte per transfer on m_tdata,
// with m_tlast marking the last byte of a packet and m_tuser flagging a length
// error result (byte zero). cfg_we writes length_field_bytes (1 to 4) and the
// user must assert it only while the block is idle, which it does not enforce.
// Each accepted byte is parsed in the cycle it arrives and may become a
// command in a short queue; the emitter expands a start command into the four
// bytes 00 00 00 01 and passes payload bytes through an output register. An
// accepted byte is held in a queue entry, then in the output register.
// Payload bytes flow at one per cycle unless stalled; each NAL header costs
// one input byte per prefix byte and four output bytes, so the output port
// sets the sustained rate and the queue absorbs start-code bursts.
// When the receiver stalls, the output register holds its byte and the queue
// fills; s_tready falls only when the queue is full.
// Reset sets length_field_bytes to 4, empties the queue and waits for a
// packet_start; bytes outside a packet are dropped.
module length_prefixed_nal_to_annexb_unit #(
  parameter int PACKET_SIZE_BITS = lpna_pkg::PACKET_SIZE_BITS_DEF,
  parameter int QUEUE_DEPTH      = lpna_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  // data_byte [7:0], packet_size above it, zero padded to whole bytes
  input  logic [((8 + PACKET_SIZE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // packet_start
  input  logic       s_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  // out_byte [7:0]
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  // length_error
  output logic       m_tuser
);

  logic           push, q_full, pop, q_valid;
  lpna_pkg::cmd_t push_cmd, head;

  lpna_front #(
    .PACKET_SIZE_BITS(PACKET_SIZE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lpna_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  lpna_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
